@@ rtl/core/peak_booking_overlap_defines.svh @@
// Assertion macros used by the peak booking overlap port-level checker.
`ifndef PEAK_BOOKING_OVERLAP_DEFINES_SVH
`define PEAK_BOOKING_OVERLAP_DEFINES_SVH

// Same-cycle implication, idle while reset is asserted.
`define PBO_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle while reset is asserted.
`define PBO_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also watches the reset itself.
`define PBO_CHECK_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pbo_pkg.sv @@
// Shared constants, types and token formats of the peak booking overlap block.
package pbo_pkg;

  // Table and counter sizing.
  localparam int TableDepth = 256;
  localparam int CountWidth = 16;
  localparam int DeltaWidth = CountWidth + 1;
  localparam int UsedWidth  = $clog2(TableDepth + 1);
  localparam int StampWidth = 32;
  localparam int PeakWidth  = 16;

  typedef logic        [StampWidth-1:0] stamp_t;
  typedef logic signed [DeltaWidth-1:0] delta_t;
  typedef logic        [CountWidth-1:0] count_t;
  typedef logic        [UsedWidth-1:0]  used_t;
  typedef logic        [PeakWidth-1:0]  peak_t;

  // Occupancy changes carried by the start and end points of a booking.
  localparam delta_t DeltaUp   = delta_t'(1);
  localparam delta_t DeltaDown = delta_t'(-1);

  // A time point travelling down the insertion lane.
  typedef struct packed {
    logic   vld;
    stamp_t stamp;
    delta_t delta;
  } ins_tok_t;

  // A scan token travelling down the scan lane behind the insertions.
  typedef struct packed {
    logic   vld;
    logic   probe;
    logic   rej;
    stamp_t s;
    stamp_t e;
    delta_t run;
    count_t best;
    used_t  used;
    logic   hit_s;
    logic   hit_e;
  } wave_t;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic  vld;
    peak_t peak;
    logic  rej;
  } res_t;

endpackage

@@ rtl/core/pbo_if.sv @@
// Request and result channel interfaces of the peak booking overlap block.
interface pbo_req_if;
  logic            valid;
  logic            ready;
  pbo_pkg::stamp_t start_time;
  pbo_pkg::stamp_t end_time;

  modport source (output valid, output start_time, output end_time, input ready);
  modport sink (input valid, input start_time, input end_time, output ready);
endinterface

interface pbo_rsp_if;
  logic           valid;
  logic           ready;
  pbo_pkg::peak_t peak_overlap;
  logic           rejected;

  modport source (output valid, output peak_overlap, output rejected, input ready);
  modport sink (input valid, input peak_overlap, input rejected, output ready);
endinterface

@@ rtl/core/pbo_cell.sv @@
// One cell of the sorted time-point chain: holds a point, inserts and scans.
module pbo_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  pbo_pkg::ins_tok_t ins_in,
  output pbo_pkg::ins_tok_t ins_out,
  input  pbo_pkg::wave_t    wave_in,
  output pbo_pkg::wave_t    wave_out
);

  logic            occ;
  pbo_pkg::stamp_t stamp;
  pbo_pkg::delta_t delta;
  pbo_pkg::wave_t  wave_next;

  // Scan step: add this point to the running sum and track the maximum.
  always_comb begin
    wave_next = wave_in;
    if (occ) begin
      wave_next.run = wave_in.run + delta;
      if (wave_next.run > $signed({1'b0, wave_in.best})) begin
        wave_next.best = wave_next.run[pbo_pkg::CountWidth-1:0];
      end
      wave_next.used  = wave_in.used + pbo_pkg::UsedWidth'(1);
      wave_next.hit_s = wave_in.hit_s | (stamp == wave_in.s);
      wave_next.hit_e = wave_in.hit_e | (stamp == wave_in.e);
    end
  end

  // Insertion step: keep, merge, take the point and pass ours on, or pass it on.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ          <= 1'b0;
      ins_out.vld  <= 1'b0;
      wave_out.vld <= 1'b0;
    end else if (adv) begin
      ins_out  <= ins_in;
      ins_out.vld <= 1'b0;
      wave_out <= wave_next;
      if (ins_in.vld) begin
        priority if (!occ) begin
          occ   <= 1'b1;
          stamp <= ins_in.stamp;
          delta <= ins_in.delta;
        end else if (ins_in.stamp == stamp) begin
          delta <= delta + ins_in.delta;
        end else if (ins_in.stamp < stamp) begin
          stamp   <= ins_in.stamp;
          delta   <= ins_in.delta;
          ins_out <= '{vld: 1'b1, stamp: stamp, delta: delta};
        end else begin
          ins_out.vld <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/pbo_ctrl.sv @@
// Request sequencer: room check, point launch, probe scans and result selection.
module pbo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  pbo_req_if.sink           req,
  input  pbo_pkg::wave_t    wave_exit,
  output pbo_pkg::ins_tok_t ins_tok,
  output pbo_pkg::wave_t    wave_tok,
  output pbo_pkg::res_t     res
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEND_E = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_PROBE  = 2'd3;

  localparam int RoomWidth = pbo_pkg::UsedWidth + 2;
  localparam int FitWidth  = pbo_pkg::UsedWidth + 1;

  logic [1:0]      state;
  pbo_pkg::stamp_t s_reg;
  pbo_pkg::stamp_t e_reg;
  pbo_pkg::count_t bookings;
  pbo_pkg::used_t  used_known;
  pbo_pkg::used_t  inflight;
  pbo_pkg::wave_t  pend;

  logic       accept;
  logic       cnt_full;
  logic       room_fast;
  logic       exit_grow;
  logic       probe_done;
  logic       probe_fits;
  logic       launch;
  logic [1:0] needed;

  // Fresh scan token with empty running state.
  function automatic pbo_pkg::wave_t make_wave(logic probe, logic rej,
                                               pbo_pkg::stamp_t s, pbo_pkg::stamp_t e);
    pbo_pkg::wave_t w;
    w       = '0;
    w.vld   = 1'b1;
    w.probe = probe;
    w.rej   = rej;
    w.s     = s;
    w.e     = e;
    return w;
  endfunction

  // Clamp the peak to the width of the result field.
  function automatic pbo_pkg::peak_t sat_peak(pbo_pkg::count_t best);
    logic [32:0] wide;
    wide = 33'(best);
    return (wide > 33'd65535) ? 16'hFFFF : wide[15:0];
  endfunction

  assign req.ready = adv && (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign cnt_full  = (bookings == '1);

  // Upper bound on points once every launched booking has landed, plus two.
  assign room_fast = (RoomWidth'(used_known) + (RoomWidth'(inflight) << 1) + RoomWidth'(2))
                     <= RoomWidth'(pbo_pkg::TableDepth);

  // Exact room check from a probe scan of the settled table.
  assign needed     = 2'(!wave_exit.hit_s) +
                      2'(!wave_exit.hit_e && (wave_exit.s != wave_exit.e));
  assign probe_fits = (FitWidth'(needed) + FitWidth'(wave_exit.used))
                      <= FitWidth'(pbo_pkg::TableDepth);
  assign probe_done = (state == ST_PROBE) && wave_exit.vld && wave_exit.probe;
  assign exit_grow  = wave_exit.vld && !wave_exit.probe && !wave_exit.rej;

  assign launch = adv && (((state == ST_IDLE) && accept && !cnt_full && room_fast) ||
                          ((state == ST_DRAIN) && (inflight == '0) && room_fast) ||
                          (probe_done && probe_fits));

  // A probe that found room is internal; every other scan is a result.
  always_comb begin
    res.vld  = wave_exit.vld && !(wave_exit.probe && probe_fits);
    res.rej  = wave_exit.rej || wave_exit.probe;
    res.peak = sat_peak(wave_exit.best);
  end

  // Sequencer: start point, end point, then the scan through pend; drain and probe near a full table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bookings     <= '0;
      used_known   <= '0;
      inflight     <= '0;
      ins_tok.vld  <= 1'b0;
      wave_tok.vld <= 1'b0;
      pend.vld     <= 1'b0;
    end else if (adv) begin
      ins_tok.vld <= 1'b0;
      wave_tok    <= pend;
      pend.vld    <= 1'b0;
      inflight    <= inflight + pbo_pkg::UsedWidth'(launch) - pbo_pkg::UsedWidth'(exit_grow);
      if (launch) begin
        bookings <= bookings + pbo_pkg::CountWidth'(1);
      end
      if (wave_exit.vld) begin
        used_known <= wave_exit.used;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            s_reg <= req.start_time;
            e_reg <= req.end_time;
            priority if (cnt_full) begin
              pend <= make_wave(1'b0, 1'b1, req.start_time, req.end_time);
            end else if (room_fast) begin
              ins_tok <= '{vld: 1'b1, stamp: req.start_time, delta: pbo_pkg::DeltaUp};
              state   <= ST_SEND_E;
            end else begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_SEND_E: begin
          ins_tok <= '{vld: 1'b1, stamp: e_reg, delta: pbo_pkg::DeltaDown};
          pend    <= make_wave(1'b0, 1'b0, s_reg, e_reg);
          state   <= ST_IDLE;
        end
        ST_DRAIN: begin
          if (inflight == '0) begin
            if (room_fast) begin
              ins_tok <= '{vld: 1'b1, stamp: s_reg, delta: pbo_pkg::DeltaUp};
              state   <= ST_SEND_E;
            end else begin
              pend  <= make_wave(1'b1, 1'b0, s_reg, e_reg);
              state <= ST_PROBE;
            end
          end
        end
        ST_PROBE: begin
          if (probe_done) begin
            if (probe_fits) begin
              ins_tok <= '{vld: 1'b1, stamp: s_reg, delta: pbo_pkg::DeltaUp};
              state   <= ST_SEND_E;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/core/peak_booking_overlap.sv @@
// Top level of the peak booking overlap block: sequencer, cell chain, result register.
//
// The req channel carries one booking request [start_time, end_time). The rsp
// channel returns exactly one result per request, in request order: the peak
// number of overlapping bookings in the table after the request, and a
// rejected flag when the table had no room or the booking counter was full.
// Time points sit sorted in a chain of 256 cells. Each request sends its start
// point and then its end point into the chain, one cell per cycle while the
// chain advances, and a scan token follows behind them, summing the point
// deltas and keeping the largest running sum. While the table has room for
// two more points per request in flight, a new request is taken as soon as
// both point launches of the last one are done, without waiting for its
// result. Near a full table the sequencer waits for the chain to settle and,
// if the room check still fails, sends a probe scan first.
// Reset empties the table and clears the booking count. While a result waits
// in the output register and rsp is stalled, the whole chain holds, and no
// request is taken.
module peak_booking_overlap (
  input logic       clk,
  input logic       rst,
  pbo_req_if.sink   req,
  pbo_rsp_if.source rsp
);

  logic              adv;
  pbo_pkg::ins_tok_t ins_chain  [pbo_pkg::TableDepth+1];
  pbo_pkg::wave_t    wave_chain [pbo_pkg::TableDepth+1];
  pbo_pkg::res_t     res;
  logic              out_vld;
  pbo_pkg::peak_t    out_peak;
  logic              out_rej;

  // The chain moves whenever the output register can take a result.
  assign adv = !out_vld || rsp.ready;

  pbo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req       (req),
    .wave_exit (wave_chain[pbo_pkg::TableDepth]),
    .ins_tok   (ins_chain[0]),
    .wave_tok  (wave_chain[0]),
    .res       (res)
  );

  // Row of cells, each passing insertions and scans to its right neighbor.
  for (genvar i = 0; i < pbo_pkg::TableDepth; i++) begin : g_cell
    pbo_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ins_in   (ins_chain[i]),
      .ins_out  (ins_chain[i+1]),
      .wave_in  (wave_chain[i]),
      .wave_out (wave_chain[i+1])
    );
  end

  // Output register between the chain and the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld  <= res.vld;
      out_peak <= res.peak;
      out_rej  <= res.rej;
    end
  end

  assign rsp.valid        = out_vld;
  assign rsp.peak_overlap = out_peak;
  assign rsp.rejected     = out_rej;

endmodule

@@ rtl/core/peak_booking_overlap_checker.sv @@
// Port-level checker of the peak booking overlap block and its bind.
`include "peak_booking_overlap_defines.svh"

module peak_booking_overlap_checker (
  input logic       clk,
  input logic       rst,
  pbo_req_if.sink   req,
  pbo_rsp_if.source rsp
);

  logic [16:0]    pending;
  logic [16:0]    granted;
  pbo_pkg::peak_t last_peak;
  logic           req_fire;
  logic           rsp_fire;

  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;

  // Track requests without results, taken bookings and the last reported peak.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      granted   <= '0;
      last_peak <= '0;
    end else begin
      pending <= pending + 17'(req_fire) - 17'(rsp_fire);
      if (rsp_fire) begin
        last_peak <= rsp.peak_overlap;
        if (!rsp.rejected) begin
          granted <= granted + 17'd1;
        end
      end
    end
  end

  `PBO_CHECK_RESET(a_reset_quiet, rst, !rsp.valid, "result shown right after reset")
  `PBO_CHECK(a_no_orphan, rsp.valid, pending != 17'd0, "result with no request outstanding")
  `PBO_CHECK_NEXT(a_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.peak_overlap) && $stable(rsp.rejected), "stalled result changed")
  `PBO_CHECK(a_reject_keeps_peak, rsp.valid && rsp.rejected, rsp.peak_overlap == last_peak, "rejected request changed the peak")
  `PBO_CHECK(a_peak_bound, rsp.valid, 17'(rsp.peak_overlap) <= granted + 17'(!rsp.rejected), "peak above the number of bookings")

endmodule

bind peak_booking_overlap peak_booking_overlap_checker u_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);

@@ bench/booking_peak_checker.sv @@
// Checker that predicts and compares every peak booking overlap result.
module booking_peak_checker
  import pbo_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pbo_req_if   req,
  pbo_rsp_if   rsp,
  output int   failures,
  output int   pending
);

  localparam longint BookingLimit = (longint'(1) << CountWidth) - 1;
  localparam int     PeakMax      = (1 << PeakWidth) - 1;
  // Keep the log readable when the block is badly broken.
  localparam int     ReportCap    = 50;

  typedef struct {
    peak_t peak;
    logic  rejected;
  } outcome_t;

  // Own copy of the sorted point table and the booking count.
  stamp_t   point_stamp [TableDepth];
  delta_t   point_change [TableDepth];
  int       points_held = 0;
  longint   bookings_taken = 0;
  outcome_t awaited_outcomes [$];
  int       fail_count = 0;

  // Returns the first slot whose time is not below t, and whether it matches t.
  function automatic int find_slot(input stamp_t t, output bit hit);
    int idx;
    idx = 0;
    while (idx < points_held && point_stamp[idx] < t) idx++;
    hit = (idx < points_held) && (point_stamp[idx] == t);
    return idx;
  endfunction

  // Adds a change at time t, opening a new slot when the time is not present.
  function automatic void add_change(input stamp_t t, input delta_t d);
    int idx;
    bit hit;
    idx = find_slot(t, hit);
    if (hit) begin
      point_change[idx] = point_change[idx] + d;
      return;
    end
    if (points_held >= TableDepth) return;
    for (int j = points_held; j > idx; j--) begin
      point_stamp[j]  = point_stamp[j-1];
      point_change[j] = point_change[j-1];
    end
    point_stamp[idx]  = t;
    point_change[idx] = d;
    points_held++;
  endfunction

  // Largest running sum over the table, floored at zero and clamped to the port.
  function automatic peak_t table_peak();
    int run;
    int best;
    run  = 0;
    best = 0;
    for (int i = 0; i < points_held; i++) begin
      run += int'(point_change[i]);
      if (run > best) best = run;
    end
    if (best > PeakMax) best = PeakMax;
    return peak_t'(best);
  endfunction

  // Applies one booking request to the table and returns the result it causes.
  function automatic outcome_t book_and_peak(input stamp_t first, input stamp_t after);
    bit       hit_first;
    bit       hit_after;
    int       needed;
    outcome_t res;
    void'(find_slot(first, hit_first));
    void'(find_slot(after, hit_after));
    needed = 0;
    if (!hit_first) needed++;
    if (!hit_after && after != first) needed++;
    res.rejected = (bookings_taken >= BookingLimit) || (needed > TableDepth - points_held);
    if (!res.rejected) begin
      add_change(first, DeltaUp);
      add_change(after, DeltaDown);
      bookings_taken++;
    end
    res.peak = table_peak();
    return res;
  endfunction

  // Predict on each accepted request and compare each accepted result in order.
  always @(posedge clk) begin
    outcome_t due;
    if (rst) begin
      points_held    = 0;
      bookings_taken = 0;
      awaited_outcomes.delete();
    end else begin
      if (req.valid && req.ready) begin
        awaited_outcomes.push_back(book_and_peak(req.start_time, req.end_time));
      end
      if (rsp.valid && rsp.ready) begin
        if (awaited_outcomes.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportCap) begin
            $error("unexpected result: peak_overlap %0d, rejected %0b",
                   rsp.peak_overlap, rsp.rejected);
          end
        end else begin
          due = awaited_outcomes.pop_front();
          if (rsp.peak_overlap !== due.peak) begin
            fail_count++;
            if (fail_count <= ReportCap) begin
              $error("peak_overlap: expected %0d, actual %0d", due.peak, rsp.peak_overlap);
            end
          end
          if (rsp.rejected !== due.rejected) begin
            fail_count++;
            if (fail_count <= ReportCap) begin
              $error("rejected: expected %0b, actual %0b", due.rejected, rsp.rejected);
            end
          end
        end
      end
    end
    failures <= fail_count;
    pending  <= awaited_outcomes.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the peak booking overlap testbench: clock, reset, stimulus and verdict.
module testbench;
  import pbo_pkg::*;

  // Several times as long as a request near a full table takes.
  localparam int     QuietLimit      = 5000;
  // Longer than the time a result takes to come out.
  localparam int     SettleCycles    = 600;
  localparam int     RandomBookings  = 900;
  // Bookings left below the counter limit when the random part starts.
  localparam int     CounterHeadroom = 500;
  localparam longint BookingLimit    = (longint'(1) << CountWidth) - 1;
  localparam stamp_t LowMark         = 100;
  localparam stamp_t HighMark        = 200;

  logic   clk = 1'b0;
  logic   rst;
  int     failures;
  int     pending;
  bit     idling_on = 1'b1;
  int     sent = 0;
  int     quiet_cycles = 0;
  stamp_t issued_stamps [$];

  pbo_req_if req_ch ();
  pbo_rsp_if rsp_ch ();

  peak_booking_overlap i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  booking_peak_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .failures (failures),
    .pending  (pending)
  );

  always #2 clk = ~clk;

  // Watchdog: end the run when nothing has moved on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: stall a random number of cycles before taking each result.
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = idling_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // Offers one booking request after a random gap and waits until it is taken.
  task automatic send_booking(input stamp_t first, input stamp_t after);
    int gap;
    gap = idling_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.start_time <= first;
    req_ch.end_time   <= after;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // Holds requests back until every expected result has come out.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly reuses earlier times so bookings land on existing points.
  function automatic stamp_t pick_stamp();
    int unsigned roll;
    stamp_t      t;
    roll = $urandom_range(0, 9);
    if (roll < 7 && issued_stamps.size() > 0) begin
      t = issued_stamps[$urandom_range(0, issued_stamps.size() - 1)];
    end else begin
      case (roll)
        8: begin
          t = stamp_t'($urandom_range(0, 63));
        end
        9: begin
          t = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        default: begin
          t = stamp_t'($urandom);
        end
      endcase
      issued_stamps.push_back(t);
    end
    return t;
  endfunction

  // Stimulus: directed cases, a long run up the booking counter, then random bookings.
  initial begin
    stamp_t first;
    stamp_t after;
    int     bulk;
    int     pick;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.start_time <= '0;
    req_ch.end_time   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Plain bookings, overlap, and two bookings that only touch at a boundary.
    send_booking(10, 20);
    send_booking(15, 25);
    send_booking(20, 30);
    // Widest possible booking and empty bookings at both ends of the time range.
    send_booking('0, '1);
    send_booking('1, '1);
    send_booking('0, '0);
    send_booking(5, 5);
    // Reversed bookings drive running sums below zero, mixed with forward and empty ones.
    send_booking(40, 35);
    send_booking('1, '0);
    send_booking(32'hAAAA_AAAA, 32'h5555_5555);
    send_booking(32'h5555_5555, 32'hAAAA_AAAA);
    send_booking(32'h8000_0000, 32'h7FFF_FFFF);
    send_booking(10, 20);
    send_booking(25, 15);
    send_booking(LowMark, HighMark);
    send_booking(HighMark, HighMark);
    drain_results();

    // Climb the booking counter close to its limit on two existing points, no idling.
    idling_on = 1'b0;
    bulk = int'(BookingLimit) - CounterHeadroom - sent;
    for (int n = 0; n < bulk; n++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0, 1, 2: begin
          send_booking(LowMark, HighMark);
        end
        3, 4: begin
          send_booking(HighMark, LowMark);
        end
        default: begin
          first = ($urandom_range(0, 1) != 0) ? LowMark : HighMark;
          send_booking(first, first);
        end
      endcase
    end
    drain_results();

    // Random bookings fill the table and then run the counter into its limit.
    issued_stamps.push_back(LowMark);
    issued_stamps.push_back(HighMark);
    for (int n = 0; n < RandomBookings; n++) begin
      idling_on = (n % 150) < 120;
      if (n == RandomBookings / 2) drain_results();
      first = pick_stamp();
      after = ($urandom_range(0, 9) == 0) ? first : pick_stamp();
      send_booking(first, after);
    end
    drain_results();
    repeat (SettleCycles) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
